>>> rtl/rwst_pkg.sv
`timescale 1ns / 1ps

package rwst_pkg;

	localparam int GRID_MAX_DEF  = 64;
	localparam int SIDE_W        = 7;
	localparam int START_W       = 6;
	localparam int CELL_OUT_W    = 12;
	localparam int EPOCH_W       = 4;
	localparam int GRID_SIDE_RST = 64;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef struct packed {
		opcode_t              opcode;
		logic [START_W-1:0]   start_x;
		logic [START_W-1:0]   start_y;
		dir_t                 direction;
	} in_item_t;

	typedef struct packed {
		logic                  wall_valid;
		logic [CELL_OUT_W-1:0] entered_cell;
		logic [CELL_OUT_W-1:0] previous_cell;
		logic                  done_res;
	} out_item_t;

	typedef struct packed {
		logic      push;
		out_item_t item;
	} res_push_t;

	typedef struct packed {
		logic full;
	} outq_stat_t;

	typedef struct packed {
		logic active;
		logic sweeping;
		logic busy;
	} walk_stat_t;

endpackage

>>> rtl/rwst_ram.sv
`timescale 1ns / 1ps

module rwst_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/rwst_outq.sv
`timescale 1ns / 1ps

module rwst_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rwst_pkg::res_push_t    push,
	output logic                   res_valid,
	input  logic                   res_ready,
	output rwst_pkg::out_item_t    res,
	output rwst_pkg::outq_stat_t   qstat
);

	import rwst_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	out_item_t        slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign res_valid   = (count_q != '0);
	assign res         = slot_q[rd_q];
	assign pop         = res_valid && res_ready;
	assign qstat.full  = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			slot_q[wr_q] <= push.item;
		end
	end

endmodule

>>> rtl/rwst_walker.sv
`timescale 1ns / 1ps

module rwst_walker #(
	parameter int GRID_MAX = rwst_pkg::GRID_MAX_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cmd_valid,
	output logic                                     cmd_ready,
	input  rwst_pkg::in_item_t                       cmd,
	input  logic                                     cfg_we,
	input  logic [rwst_pkg::SIDE_W-1:0]              cfg_wdata,
	input  rwst_pkg::outq_stat_t                     qstat,
	output rwst_pkg::res_push_t                      push,
	output rwst_pkg::walk_stat_t                     stat,
	output logic                                     ram_we,
	output logic [$clog2(GRID_MAX*GRID_MAX)-1:0]     ram_waddr,
	output logic [rwst_pkg::EPOCH_W-1:0]             ram_wdata,
	output logic [$clog2(GRID_MAX*GRID_MAX)-1:0]     ram_raddr,
	input  logic [rwst_pkg::EPOCH_W-1:0]             ram_rdata
);

	import rwst_pkg::*;

	localparam int CELLS    = GRID_MAX * GRID_MAX;
	localparam int IDX_W    = $clog2(CELLS);
	localparam int CNT_W    = IDX_W + 1;
	localparam int COORD_W  = $clog2(GRID_MAX);
	localparam int SIDE_I_W = $clog2(GRID_MAX + 1);
	localparam int SE_W     = (SIDE_I_W > SIDE_W) ? SIDE_I_W : SIDE_W;
	localparam int SC_W     = (SIDE_I_W > START_W) ? SIDE_I_W : START_W;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

	logic [SIDE_W-1:0]   grid_side_q;
	logic [COORD_W-1:0]  row_q;
	logic [COORD_W-1:0]  col_q;
	logic [IDX_W-1:0]    cells_left_q;
	logic                active_q;
	logic [EPOCH_W-1:0]  epoch_q;
	logic                sweep_q;
	logic [IDX_W-1:0]    sweep_addr_q;
	logic [IDX_W-1:0]    mark_idx_q;
	logic                valid_s1;
	logic                start_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [IDX_W-1:0]    prev_s1;

	logic [SE_W-1:0]     side_raw;
	logic [SIDE_I_W-1:0] side;
	logic [SIDE_I_W-1:0] side_m1;
	logic [COORD_W-1:0]  sat_col;
	logic [COORD_W-1:0]  sat_row;
	logic                is_start;
	logic [COORD_W-1:0]  row_op;
	logic [COORD_W-1:0]  col_op;
	logic [IDX_W-1:0]    base_idx;
	logic                moved;
	logic [COORD_W-1:0]  new_row;
	logic [COORD_W-1:0]  new_col;
	logic [IDX_W-1:0]    new_idx;
	logic [CNT_W-1:0]    side_sq;
	logic [IDX_W-1:0]    start_cnt;
	logic                fire;
	logic                go_step;
	logic                wrap;
	logic                visited;
	logic                take;
	logic [IDX_W-1:0]    cnt_dec;

	assign side_raw = SE_W'(grid_side_q);

	always_comb begin
		if (side_raw == '0) begin
			side = SIDE_I_W'(1);
		end else if (side_raw > SE_W'(GRID_MAX)) begin
			side = SIDE_I_W'(GRID_MAX);
		end else begin
			side = SIDE_I_W'(side_raw);
		end
	end

	assign side_m1 = side - SIDE_I_W'(1);
	assign sat_col = (SC_W'(cmd.start_x) > SC_W'(side_m1)) ? COORD_W'(side_m1)
		: COORD_W'(cmd.start_x);
	assign sat_row = (SC_W'(cmd.start_y) > SC_W'(side_m1)) ? COORD_W'(side_m1)
		: COORD_W'(cmd.start_y);

	assign is_start = (cmd.opcode == OP_START);
	assign row_op   = is_start ? sat_row : row_q;
	assign col_op   = is_start ? sat_col : col_q;
	assign base_idx = IDX_W'(row_op) * IDX_W'(side) + IDX_W'(col_op);

	always_comb begin
		moved   = 1'b0;
		new_row = row_q;
		new_col = col_q;
		new_idx = base_idx;
		unique case (cmd.direction)
			DIR_UP: begin
				moved   = (row_q != '0);
				new_row = row_q - COORD_W'(1);
				new_idx = base_idx - IDX_W'(side);
			end
			DIR_DOWN: begin
				moved   = ((SIDE_I_W'(row_q) + SIDE_I_W'(1)) < side);
				new_row = row_q + COORD_W'(1);
				new_idx = base_idx + IDX_W'(side);
			end
			DIR_LEFT: begin
				moved   = (col_q != '0);
				new_col = col_q - COORD_W'(1);
				new_idx = base_idx - IDX_W'(1);
			end
			DIR_RIGHT: begin
				moved   = ((SIDE_I_W'(col_q) + SIDE_I_W'(1)) < side);
				new_col = col_q + COORD_W'(1);
				new_idx = base_idx + IDX_W'(1);
			end
		endcase
	end

	assign side_sq   = CNT_W'(side) * CNT_W'(side);
	assign start_cnt = IDX_W'(side_sq - CNT_W'(1));

	assign cmd_ready = !sweep_q && !valid_s1 && !qstat.full;
	assign fire      = cmd_valid && cmd_ready;
	assign go_step   = fire && !is_start && active_q && moved;
	assign wrap      = (epoch_q == EPOCH_LAST);

	assign visited = (ram_rdata == epoch_q);
	assign take    = valid_s1 && !start_s1 && !visited;
	assign cnt_dec = (cells_left_q != '0) ? cells_left_q - IDX_W'(1) : '0;

	assign ram_raddr = new_idx;

	always_comb begin
		if (sweep_q) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_addr_q;
			ram_wdata = (sweep_addr_q == mark_idx_q) ? epoch_q : '0;
		end else begin
			ram_we    = valid_s1 && (start_s1 || !visited);
			ram_waddr = idx_s1;
			ram_wdata = epoch_q;
		end
	end

	assign push.push               = take;
	assign push.item.wall_valid    = 1'b1;
	assign push.item.entered_cell  = CELL_OUT_W'(idx_s1);
	assign push.item.previous_cell = CELL_OUT_W'(prev_s1);
	assign push.item.done_res      = (cnt_dec == '0);

	assign stat.active   = active_q;
	assign stat.sweeping = sweep_q;
	assign stat.busy     = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q  <= SIDE_W'(GRID_SIDE_RST);
			row_q        <= '0;
			col_q        <= '0;
			cells_left_q <= '0;
			active_q     <= 1'b0;
			epoch_q      <= '0;
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= (fire && is_start && !wrap) || go_step;
			if (cfg_we) begin
				grid_side_q <= cfg_wdata;
			end
			if (sweep_q) begin
				sweep_addr_q <= sweep_addr_q + IDX_W'(1);
				if (sweep_addr_q == IDX_W'(CELLS - 1)) begin
					sweep_q <= 1'b0;
				end
			end
			if (fire && is_start) begin
				row_q        <= sat_row;
				col_q        <= sat_col;
				cells_left_q <= start_cnt;
				active_q     <= (side != SIDE_I_W'(1));
				if (wrap) begin
					epoch_q      <= EPOCH_W'(1);
					sweep_q      <= 1'b1;
					sweep_addr_q <= '0;
				end else begin
					epoch_q  <= epoch_q + EPOCH_W'(1);
				end
			end else if (go_step) begin
				row_q    <= new_row;
				col_q    <= new_col;
			end
			if (take) begin
				cells_left_q <= cnt_dec;
				if (cnt_dec == '0) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			start_s1 <= is_start;
			idx_s1   <= is_start ? base_idx : new_idx;
			prev_s1  <= base_idx;
			if (is_start) begin
				mark_idx_q <= base_idx;
			end
		end
	end

endmodule

>>> rtl/random_walk_spanning_tree_grid_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload      Moves
// cmd       cmd_valid / cmd_ready     cmd          start or step item, one per transfer
// res       res_valid / res_ready     res          wall report, one per transfer
// cfg       cfg_we                    cfg_wdata    grid side, written at once
//
// An item that takes a map access reads the visited map in the cycle of the transfer and
// updates it in the next, and the next item waits for that update.
// A step that is ignored or blocked by the edge leaves the map alone and does not hold back the next item.
// After reset all GRID_MAX * GRID_MAX cells of the map are swept while cmd_ready stays low,
// and again on the sixteenth start after reset and on every fifteenth start after that.
// Results wait in a two-entry queue; cmd_ready also stays low while both entries are taken.

module random_walk_spanning_tree_grid_unit #(
	parameter int GRID_MAX = rwst_pkg::GRID_MAX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  rwst_pkg::in_item_t           cmd,
	output logic                         res_valid,
	input  logic                         res_ready,
	output rwst_pkg::out_item_t          res,
	input  logic                         cfg_we,
	input  logic [rwst_pkg::SIDE_W-1:0]  cfg_wdata
);

	import rwst_pkg::*;

	localparam int CELLS = GRID_MAX * GRID_MAX;
	localparam int IDX_W = $clog2(CELLS);

	res_push_t          push;
	walk_stat_t         stat;
	outq_stat_t         qstat;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [EPOCH_W-1:0] ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [EPOCH_W-1:0] ram_rdata;

	rwst_ram #(
		.WIDTH(EPOCH_W),
		.DEPTH(CELLS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rwst_walker #(
		.GRID_MAX(GRID_MAX)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.qstat    (qstat),
		.push     (push),
		.stat     (stat),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	rwst_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.qstat    (qstat)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |-> !stat.sweeping && !stat.busy)
		else $error("command transfer while the map is swept or updated");

	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		push.push && push.item.done_res |=> !stat.active)
		else $error("walk still active after the final wall");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !qstat.full || res_ready)
		else $error("result pushed into a full queue");

endmodule

>>> sim/random_walk_spanning_tree_grid_unit_test.sv
`timescale 1ns / 1ps

module random_walk_spanning_tree_grid_unit_test;
	import rwst_pkg::*;

	localparam int MAP_CELLS = GRID_MAX_DEF * GRID_MAX_DEF;
	localparam int SETTLE = MAP_CELLS + 16;

	typedef enum int {
		FLOW_FREE,
		FLOW_SENDER_IDLE,
		FLOW_RECEIVER_STALL,
		FLOW_BOTH
	} flow_t;

	typedef struct packed {
		bit               is_cfg;
		bit [SIDE_W-1:0]  side_val;
		bit               typed;
		bit               wall_due;
		in_item_t         item;
		out_item_t        wall;
	} script_row_t;

	logic              clk;
	logic              arst_n;
	logic              cmd_valid;
	logic              cmd_ready;
	in_item_t          cmd;
	logic              res_valid;
	logic              res_ready;
	out_item_t         res;
	logic              cfg_we;
	logic [SIDE_W-1:0] cfg_wdata;

	random_walk_spanning_tree_grid_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic [SIDE_W-1:0]    side_reg = 7'(GRID_SIDE_RST);
	logic [START_W-1:0]   walk_col = '0;
	logic [START_W-1:0]   walk_row = '0;
	logic [12:0]          cells_left = '0;
	bit                   walking = 1'b0;
	bit [MAP_CELLS-1:0]   visited = '0;

	out_item_t   walls_due[$];
	out_item_t   wanted;
	script_row_t script[$];
	flow_t       flow = FLOW_FREE;
	int          hold_off = 0;
	int          mismatches = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("random_walk_spanning_tree_grid_unit_test: errors");
		$finish;
	end

	function automatic int side_now();
		if (side_reg < 1)
			return 1;
		if (side_reg > GRID_MAX_DEF)
			return GRID_MAX_DEF;
		return int'(side_reg);
	endfunction

	task automatic walk_step(input in_item_t it, output bit hit, output out_item_t wall);
		int side;
		int row;
		int col;
		int prev;
		int idx;
		bit moved;
		side = side_now();
		row = int'(walk_row);
		col = int'(walk_col);
		moved = 1'b0;
		hit = 1'b0;
		wall = '0;
		if (it.opcode == OP_START) begin
			visited = '0;
			walk_col = (int'(it.start_x) > side - 1) ? 6'(side - 1) : it.start_x;
			walk_row = (int'(it.start_y) > side - 1) ? 6'(side - 1) : it.start_y;
			idx = int'(walk_row) * side + int'(walk_col);
			visited[idx] = 1'b1;
			cells_left = 13'(side * side - 1);
			walking = (cells_left != 0);
		end else if (walking) begin
			case (it.direction)
				DIR_UP: begin
					if (row > 0) begin
						row--;
						moved = 1'b1;
					end
				end
				DIR_DOWN: begin
					if (row + 1 < side) begin
						row++;
						moved = 1'b1;
					end
				end
				DIR_LEFT: begin
					if (col > 0) begin
						col--;
						moved = 1'b1;
					end
				end
				default: begin
					if (col + 1 < side) begin
						col++;
						moved = 1'b1;
					end
				end
			endcase
			if (moved) begin
				prev = int'(walk_row) * side + int'(walk_col);
				walk_row = 6'(row);
				walk_col = 6'(col);
				idx = row * side + col;
				if (!visited[idx]) begin
					visited[idx] = 1'b1;
					if (cells_left > 0)
						cells_left--;
					if (cells_left == 0)
						walking = 1'b0;
					hit = 1'b1;
					wall.wall_valid = 1'b1;
					wall.entered_cell = 12'(idx);
					wall.previous_cell = 12'(prev);
					wall.done_res = !walking;
				end
			end
		end
	endtask

	function automatic in_item_t make_item(opcode_t op, int sx, int sy, dir_t d);
		in_item_t it;
		it.opcode = op;
		it.start_x = 6'(sx);
		it.start_y = 6'(sy);
		it.direction = d;
		return it;
	endfunction

	function automatic script_row_t cfg_row(int v);
		script_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.side_val = 7'(v);
		return r;
	endfunction

	function automatic script_row_t pred_row(opcode_t op, int sx, int sy, dir_t d);
		script_row_t r;
		r = '0;
		r.item = make_item(op, sx, sy, d);
		return r;
	endfunction

	function automatic script_row_t typed_row(opcode_t op, int sx, int sy, dir_t d,
			bit due, int ent, int prv, bit dn);
		script_row_t r;
		r = '0;
		r.item = make_item(op, sx, sy, d);
		r.typed = 1'b1;
		r.wall_due = due;
		r.wall.wall_valid = due;
		r.wall.entered_cell = 12'(ent);
		r.wall.previous_cell = 12'(prv);
		r.wall.done_res = dn;
		return r;
	endfunction

	task automatic send_item(input in_item_t it);
		@(negedge clk);
		cmd <= it;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	task automatic write_side(input int v);
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (walls_due.size() != 0)
			@(posedge clk);
		// A start may still be clearing the map although no result is owed.
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 7'(v);
		side_reg = 7'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int side_val, input flow_t mode, input int n_items,
			input bit pressure);
		in_item_t  it;
		out_item_t wall;
		bit        hit;
		bit        ignored;
		bit        held;
		bit        paused;
		int        counted;
		int        r;
		int        gap;
		int        side;
		write_side(side_val);
		flow = mode;
		counted = 0;
		held = 1'b0;
		paused = 1'b0;
		while (counted < n_items) begin
			side = side_now();
			it.start_x = 6'($urandom);
			it.start_y = 6'($urandom);
			it.direction = dir_t'($urandom_range(0, 3));
			r = $urandom_range(0, 99);
			if (walking)
				it.opcode = (r < 2) ? OP_START : OP_STEP;
			else
				it.opcode = (r < 10) ? OP_STEP : OP_START;
			if (it.opcode == OP_START && $urandom_range(0, 99) < 80) begin
				it.start_x = 6'($urandom_range(0, side - 1));
				it.start_y = 6'($urandom_range(0, side - 1));
			end
			ignored = (it.opcode == OP_STEP) && !walking;
			send_item(it);
			walk_step(it, hit, wall);
			if (hit)
				walls_due.push_back(wall);
			if (!ignored)
				counted++;
			if (pressure && !held && counted >= 10) begin
				held = 1'b1;
				hold_off = 300;
			end
			gap = 0;
			if (mode == FLOW_SENDER_IDLE && $urandom_range(0, 99) < 48)
				gap = $urandom_range(1, 4);
			else if (mode == FLOW_BOTH && $urandom_range(0, 99) < 9)
				gap = $urandom_range(1, 4);
			if (gap > 0) begin
				@(negedge clk);
				cmd_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			if (pressure && !paused && counted >= n_items / 2) begin
				paused = 1'b1;
				@(negedge clk);
				cmd_valid <= 1'b0;
				while (walls_due.size() != 0)
					@(posedge clk);
			end
		end
	endtask

	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				hold_off--;
				res_ready <= 1'b0;
			end else begin
				case (flow)
					FLOW_RECEIVER_STALL: res_ready <= ($urandom_range(0, 99) >= 48);
					FLOW_BOTH:           res_ready <= ($urandom_range(0, 99) >= 9);
					default:             res_ready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (walls_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected wall transfer: entered=%0d previous=%0d done=%0d",
					$time, res.entered_cell, res.previous_cell, res.done_res);
			end else begin
				wanted = walls_due.pop_front();
				if (res !== wanted) begin
					mismatches++;
					$display("%0t: wall mismatch: expected valid=%0d entered=%0d previous=%0d done=%0d",
						$time, wanted.wall_valid, wanted.entered_cell,
						wanted.previous_cell, wanted.done_res);
					$display("%0t:                  actual valid=%0d entered=%0d previous=%0d done=%0d",
						$time, res.wall_valid, res.entered_cell,
						res.previous_cell, res.done_res);
				end
			end
		end
	end

	initial begin
		bit        hit;
		out_item_t wall;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;

		script.push_back(typed_row(OP_STEP, 0, 0, DIR_UP, 0, 0, 0, 0));
		script.push_back(typed_row(OP_START, 63, 63, DIR_RIGHT, 0, 0, 0, 0));
		script.push_back(typed_row(OP_STEP, 17, 42, DIR_DOWN, 0, 0, 0, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_RIGHT, 0, 0, 0, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_UP, 1, 4031, 4095, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_DOWN, 0, 0, 0, 0));
		script.push_back(typed_row(OP_STEP, 63, 63, DIR_LEFT, 1, 4094, 4095, 0));
		script.push_back(typed_row(OP_START, 0, 0, DIR_UP, 0, 0, 0, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_UP, 0, 0, 0, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_LEFT, 0, 0, 0, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_RIGHT, 1, 1, 0, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_DOWN, 1, 65, 1, 0));
		script.push_back(cfg_row(0));
		script.push_back(typed_row(OP_START, 5, 9, DIR_UP, 0, 0, 0, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_RIGHT, 0, 0, 0, 0));
		script.push_back(cfg_row(2));
		script.push_back(typed_row(OP_START, 63, 63, DIR_DOWN, 0, 0, 0, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_UP, 1, 1, 3, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_LEFT, 1, 0, 1, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_DOWN, 1, 2, 0, 1));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_RIGHT, 0, 0, 0, 0));
		script.push_back(cfg_row(127));
		script.push_back(typed_row(OP_START, 0, 63, DIR_LEFT, 0, 0, 0, 0));
		script.push_back(typed_row(OP_STEP, 0, 0, DIR_RIGHT, 1, 4033, 4032, 0));
		// Shrinking the grid under a live walk leaves the walker outside the new edge.
		script.push_back(cfg_row(3));
		script.push_back(pred_row(OP_STEP, 0, 0, DIR_UP));
		script.push_back(pred_row(OP_START, 10, 20, DIR_UP));
		script.push_back(pred_row(OP_STEP, 0, 0, DIR_LEFT));
		script.push_back(pred_row(OP_STEP, 0, 0, DIR_UP));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				write_side(int'(script[i].side_val));
			end else begin
				send_item(script[i].item);
				walk_step(script[i].item, hit, wall);
				if (script[i].typed) begin
					hit = script[i].wall_due;
					wall = script[i].wall;
				end
				if (hit)
					walls_due.push_back(wall);
			end
		end

		run_phase(4, FLOW_FREE, 200, 1'b0);
		run_phase(3, FLOW_SENDER_IDLE, 120, 1'b0);
		run_phase(5, FLOW_RECEIVER_STALL, 150, 1'b0);
		run_phase(2, FLOW_BOTH, 100, 1'b0);
		run_phase(64, FLOW_FREE, 80, 1'b1);
		run_phase(6, FLOW_SENDER_IDLE, 160, 1'b0);
		run_phase(1, FLOW_RECEIVER_STALL, 30, 1'b0);
		run_phase(8, FLOW_BOTH, 200, 1'b0);
		run_phase(0, FLOW_FREE, 20, 1'b0);
		run_phase(127, FLOW_RECEIVER_STALL, 40, 1'b0);
		run_phase(7, FLOW_FREE, 150, 1'b0);
		run_phase(3, FLOW_BOTH, 80, 1'b0);

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (walls_due.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		if (mismatches == 0)
			$display("random_walk_spanning_tree_grid_unit_test: clean");
		else
			$display("random_walk_spanning_tree_grid_unit_test: errors");
		$finish;
	end

endmodule

>>> random_walk_spanning_tree_grid_unit.f
rtl/rwst_pkg.sv
rtl/rwst_ram.sv
rtl/rwst_outq.sv
rtl/rwst_walker.sv
rtl/random_walk_spanning_tree_grid_unit.sv
sim/random_walk_spanning_tree_grid_unit_test.sv
